@@ rtl/cea_pkg.sv @@
// ----------------------------------------------------------------------------
// cea_pkg - shared types and constants for the contiguous extent allocator
// Holds the request and result word types, status codes, the controller
// state type and the command/flag bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cea_pkg;

  // default sizing
  localparam int MAX_EXTENTS_DEF = 32;
  localparam int MAX_BLOCKS_DEF  = 1024;
  localparam int TOTAL_RESET     = 1024;

  // field widths
  localparam int START_W = 10;
  localparam int COUNT_W = 11;
  localparam int SLOT_W  = 5;
  localparam int STAT_W  = 3;

  // register map: word index of the device size register
  localparam logic REG_TOTAL = 1'b0;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 3'd0,
    ST_NO_FREE     = 3'd1,
    ST_START_TAKEN = 3'd2,
    ST_OVERLAP     = 3'd3,
    ST_PAST_END    = 3'd4,
    ST_FULL        = 3'd5
  } status_t;

  typedef struct packed {
    logic [START_W-1:0] start_block;
    logic [COUNT_W-1:0] block_count;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] free_left;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE_CHK,
    S_SCAN,
    S_TAIL,
    S_REPLY
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic free_chk;
    logic scan;
    logic tail;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic no_free;
    logic empty;
    logic hit;
    logic last;
  } flags_t;

  // configuration write
  typedef struct packed {
    logic               wr;
    logic [COUNT_W-1:0] data;
  } cfg_wr_t;

endpackage

@@ rtl/cea_ctrl.sv @@
// ----------------------------------------------------------------------------
// cea_ctrl - sequencer for the extent allocator
// Steps one request through free check, table scan, tail checks and reply.
// ----------------------------------------------------------------------------
module cea_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  cea_pkg::flags_t flags,
  output cea_pkg::cmd_t   cmd,
  output logic            busy,
  output logic            done
);
  import cea_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    busy         = 1'b1;
    done         = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_FREE_CHK;
        end
      end
      S_FREE_CHK: begin
        cmd.free_chk = 1'b1;
        if (flags.no_free) begin
          state_next = S_REPLY;
        end else if (flags.empty) begin
          state_next = S_TAIL;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (flags.hit) begin
          state_next = S_REPLY;
        end else if (flags.last) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd.tail   = 1'b1;
        state_next = S_REPLY;
      end
      S_REPLY: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/cea_dp.sv @@
// ----------------------------------------------------------------------------
// cea_dp - datapath of the extent allocator
// Request latch, extent table memory, scan counter, free/used counters,
// overlap compare and the result word register.
// ----------------------------------------------------------------------------
module cea_dp #(
  parameter int MAX_EXTENTS = cea_pkg::MAX_EXTENTS_DEF,
  parameter int MAX_BLOCKS  = cea_pkg::MAX_BLOCKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cea_pkg::req_t             req,
  input  cea_pkg::cmd_t             cmd,
  input  cea_pkg::cfg_wr_t          cfg,
  output cea_pkg::flags_t           flags,
  output cea_pkg::res_t             result,
  output logic [cea_pkg::COUNT_W-1:0] total
);
  import cea_pkg::*;

  localparam int AW = $clog2(MAX_EXTENTS);
  localparam int UW = $clog2(MAX_EXTENTS + 1);
  localparam int LIMIT_INT = (MAX_BLOCKS > 2047) ? 2047 : MAX_BLOCKS;
  localparam int RESET_INT = (TOTAL_RESET > MAX_BLOCKS) ? MAX_BLOCKS : TOTAL_RESET;
  localparam logic [COUNT_W-1:0] TOTAL_LIMIT = COUNT_W'(LIMIT_INT);
  localparam logic [COUNT_W-1:0] TOTAL_RST   = COUNT_W'(RESET_INT);
  localparam logic [UW-1:0]      USED_MAX    = UW'(MAX_EXTENTS);

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [COUNT_W-1:0] len;
  } entry_t;

  entry_t             mem [MAX_EXTENTS];
  entry_t             rd;
  req_t               cur;
  logic [UW-1:0]      idx;
  logic [UW-1:0]      used;
  logic [COUNT_W-1:0] free_blocks;
  logic [COUNT_W-1:0] cfg_total;
  logic [START_W+1:0] old_end;
  logic [START_W+1:0] new_end;
  logic               same_start;
  logic               overlap;
  logic               past_end;
  status_t            res_status;
  logic [SLOT_W-1:0]  res_slot;

  // saturate a written device size
  assign cfg_total = (cfg.data > TOTAL_LIMIT) ? TOTAL_LIMIT : cfg.data;

  // compares against the entry read last cycle
  assign old_end    = (START_W+2)'(rd.start) + (START_W+2)'(rd.len);
  assign new_end    = (START_W+2)'(cur.start_block) + (START_W+2)'(cur.block_count);
  assign same_start = (cur.start_block == rd.start);
  assign overlap    = ((START_W+2)'(cur.start_block) < old_end) &&
                      ((START_W+2)'(rd.start) < new_end);
  assign past_end   = (new_end > (START_W+2)'(total));

  assign flags.no_free = (cur.block_count > free_blocks);
  assign flags.empty   = (used == '0);
  assign flags.hit     = same_start || overlap;
  assign flags.last    = (idx == used);

  // extent table: registered read at the scan index, write on commit
  always_ff @(posedge clk) begin
    rd <= mem[idx[AW-1:0]];
    if (cmd.tail && !past_end && (used != USED_MAX)) begin
      mem[used[AW-1:0]] <= '{start: cur.start_block, len: cur.block_count};
    end
  end

  // control counters and device size
  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      used        <= '0;
      total       <= TOTAL_RST;
      free_blocks <= TOTAL_RST;
    end else begin
      if (cfg.wr) begin
        total       <= cfg_total;
        free_blocks <= cfg_total;
      end
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.free_chk || cmd.scan) begin
        idx <= idx + UW'(1);
      end
      if (cmd.tail && !past_end && (used != USED_MAX)) begin
        used        <= used + UW'(1);
        free_blocks <= free_blocks - cur.block_count;
      end
    end
  end

  // request latch and result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
    end
    if (cmd.free_chk && flags.no_free) begin
      res_status <= ST_NO_FREE;
      res_slot   <= '0;
    end
    if (cmd.scan && flags.hit) begin
      res_status <= same_start ? ST_START_TAKEN : ST_OVERLAP;
      res_slot   <= '0;
    end
    if (cmd.tail) begin
      if (past_end) begin
        res_status <= ST_PAST_END;
        res_slot   <= '0;
      end else if (used == USED_MAX) begin
        res_status <= ST_FULL;
        res_slot   <= '0;
      end else begin
        res_status <= ST_OK;
        res_slot   <= SLOT_W'(used);
      end
    end
  end

  // free count after the request, valid in the reply cycle
  assign result = '{status: res_status, slot: res_slot, free_left: free_blocks};

endmodule

@@ rtl/contiguous_extent_allocator_top.sv @@
// ----------------------------------------------------------------------------
// contiguous_extent_allocator_top - contiguous extent allocator
// Checks a request for a run of blocks against the free count, the stored
// extents and the device size, and stores it in the next table slot.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req and raise start; the word is taken at a clock
//   edge with start high and busy low. busy stays high until the reply.
//   Result channel: done is high for one cycle with result holding status,
//   slot and the free count after the request. The receiver cannot stall.
//   Sequence: a request short of free blocks goes from the free check to
//   the reply; otherwise the table scan follows (skipped for an empty
//   table), then the tail checks unless the scan hits. The scan reads
//   one table entry per cycle from the extent memory; a new request can
//   be taken in the cycle after done.
//   Config: APB port, device size register at byte address 0; a write
//   keeps the low 11 bits of pwdata, saturates them to MAX_BLOCKS and
//   reloads the free count. Write only while busy is low.
//   Reset: table empty, total and free count at 1024 (limited to
//   MAX_BLOCKS). Table contents need no clearing pass; a fill count marks
//   which slots hold extents.
// ----------------------------------------------------------------------------
module contiguous_extent_allocator_top #(
  parameter int MAX_EXTENTS = cea_pkg::MAX_EXTENTS_DEF,
  parameter int MAX_BLOCKS  = cea_pkg::MAX_BLOCKS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  cea_pkg::req_t req,
  output logic          done,
  output cea_pkg::res_t result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import cea_pkg::*;

  cmd_t               cmd;
  flags_t             flags;
  cfg_wr_t            cfg;
  logic               busy_i;
  logic [COUNT_W-1:0] total;

  // APB decode
  assign pready   = 1'b1;
  assign cfg.wr   = psel && penable && pwrite && (paddr[2] == REG_TOTAL);
  assign cfg.data = pwdata[COUNT_W-1:0];
  assign prdata   = (paddr[2] == REG_TOTAL) ? {{(32-COUNT_W){1'b0}}, total} : '0;

  assign busy = busy_i;

  cea_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .cmd   (cmd),
    .busy  (busy_i),
    .done  (done)
  );

  cea_dp #(
    .MAX_EXTENTS (MAX_EXTENTS),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .cfg    (cfg),
    .flags  (flags),
    .result (result),
    .total  (total)
  );

endmodule

@@ tb/sv/contiguous_extent_allocator_top_test.sv @@
// ----------------------------------------------------------------------------
// contiguous_extent_allocator_top_test - regression for the extent allocator
// Drives allocation requests through the start/busy port and device size
// writes through the APB port. A ledger class keeps its own copy of the
// extent table, free count and device size, predicts the reply word for each
// accepted request and checks every done word against it in order.
// ----------------------------------------------------------------------------
module contiguous_extent_allocator_top_test;
  import cea_pkg::*;

  localparam int EXTENTS     = MAX_EXTENTS_DEF;
  localparam int BLOCKS      = MAX_BLOCKS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 257;
  localparam int SETTLE      = EXTENTS + 8;
  localparam logic [2:0] TOTAL_ADDR = 3'(4 * REG_TOTAL);

  // --------------------------------------------------------------------------
  // Ledger: extent table copy, reply prediction and reply checking
  // --------------------------------------------------------------------------
  class extent_ledger;
    logic [START_W-1:0] ext_start [EXTENTS];
    logic [COUNT_W-1:0] ext_len [EXTENTS];
    bit                 ext_used [EXTENTS];
    int                 slots_used;
    int                 free_blocks;
    int                 dev_size;
    res_t               expected_replies [$];
    int                 errors;

    function new();
      for (int i = 0; i < EXTENTS; i++) begin
        ext_used[i] = 1'b0;
      end
      slots_used  = 0;
      dev_size    = (TOTAL_RESET > BLOCKS) ? BLOCKS : TOTAL_RESET;
      free_blocks = dev_size;
      errors      = 0;
    endfunction

    // device size write: keep 11 bits, saturate, reload free count
    function void set_total(logic [31:0] value);
      int v;
      v = int'(value[COUNT_W-1:0]);
      dev_size    = (v > BLOCKS) ? BLOCKS : v;
      free_blocks = dev_size;
    endfunction

    // checks in fixed order: free count, table scan, device end, full table
    function status_t judge_request(int s, int c);
      int a;
      int l;
      if (c > free_blocks) return ST_NO_FREE;
      for (int i = 0; i < EXTENTS; i++) begin
        if (ext_used[i]) begin
          a = int'(ext_start[i]);
          l = int'(ext_len[i]);
          if (s == a) return ST_START_TAKEN;
          if (s < a + l && a < s + c) return ST_OVERLAP;
        end
      end
      if (s + c > dev_size) return ST_PAST_END;
      if (slots_used >= EXTENTS) return ST_FULL;
      return ST_OK;
    endfunction

    function void note_request(req_t r);
      res_t    exp_word;
      status_t st;
      int      s;
      int      c;
      s  = int'(r.start_block);
      c  = int'(r.block_count);
      st = judge_request(s, c);
      exp_word.status = st;
      exp_word.slot   = '0;
      if (st == ST_OK) begin
        exp_word.slot = SLOT_W'(slots_used);
        ext_start[slots_used] = r.start_block;
        ext_len[slots_used]   = r.block_count;
        ext_used[slots_used]  = 1'b1;
        slots_used++;
        free_blocks -= c;
      end
      exp_word.free_left = COUNT_W'(free_blocks);
      expected_replies.push_back(exp_word);
    endfunction

    function void compare_field(string name, logic [31:0] expv, logic [31:0] actv);
      if (expv !== actv) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expv, actv);
        errors++;
      end
    endfunction

    function void check_reply(res_t got);
      res_t exp_word;
      if (expected_replies.size() == 0) begin
        $display("%0t: reply with nothing expected, actual status %0d slot %0d free %0d",
                 $time, got.status, got.slot, got.free_left);
        errors++;
        return;
      end
      exp_word = expected_replies.pop_front();
      compare_field("status", 32'(exp_word.status), 32'(got.status));
      compare_field("slot", 32'(exp_word.slot), 32'(got.slot));
      compare_field("free_left", 32'(exp_word.free_left), 32'(got.free_left));
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // start block of some stored extent, for start-taken requests
    function logic [START_W-1:0] stored_start();
      if (slots_used == 0) return START_W'($urandom_range(0, 1023));
      return ext_start[$urandom_range(0, slots_used - 1)];
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        start   = 1'b0;
  req_t        req     = '0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic        busy;
  logic        done;
  res_t        result;
  logic [31:0] prdata;
  logic        pready;

  int           cycle_count = 0;
  extent_ledger ledger = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  contiguous_extent_allocator_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // reply monitor: done words are taken at the edge ending their cycle
  always @(posedge clk) begin
    if (!rst && done) begin
      ledger.check_reply(result);
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("contiguous_extent_allocator_top regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic req_t mk_req(int s, int c);
    req_t r;
    r.start_block = START_W'(s);
    r.block_count = COUNT_W'(c);
    return r;
  endfunction

  // one request word; start stays high across back-to-back words
  task automatic send_request(req_t r, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    ledger.note_request(r);
  endtask

  // hold off until every reply is in and the block is idle
  task automatic wait_drain();
    start <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_total(logic [31:0] value);
    wait_drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TOTAL_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ledger.set_total(value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly small well-formed requests, with taken starts and oversize noise
  function automatic req_t random_request();
    int kind;
    int s;
    int c;
    kind = $urandom_range(0, 99);
    s    = $urandom_range(0, 1023);
    if (kind < 55) begin
      c = $urandom_range(0, 15);
    end else if (kind < 70) begin
      c = $urandom_range(16, 200);
    end else if (kind < 80) begin
      c = $urandom_range(0, 2047);
    end else if (kind < 92) begin
      s = int'(ledger.stored_start());
      c = $urandom_range(0, 15);
    end else begin
      case ($urandom_range(0, 3))
        0: c = 0;
        1: c = 1024;
        2: c = 2047;
        default: c = $urandom_range(1000, 1100);
      endcase
      if ($urandom_range(0, 1) == 1) s = ($urandom_range(0, 1) == 1) ? 1023 : 0;
    end
    return mk_req(s, c);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] phase_total [7];
    bit          no_gaps;
    int          gap;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero count, taken start, end and free limits, covering overlap
    send_request(mk_req(0, 0), 0);
    send_request(mk_req(0, 1), 3);
    send_request(mk_req(1, 1024), 0);
    send_request(mk_req(1, 1025), 0);
    send_request(mk_req(1023, 2047), 5);
    send_request(mk_req(1023, 1), 0);
    send_request(mk_req(100, 10), 9);
    send_request(mk_req(50, 100), 0);
    send_request(mk_req(105, 1), 1);
    send_request(mk_req(109, 1), 0);
    send_request(mk_req(110, 5), 0);
    send_request(mk_req(99, 1), 2);
    send_request(mk_req(1022, 2), 0);
    write_total(32'd0);
    send_request(mk_req(500, 0), 0);
    send_request(mk_req(500, 1), 4);
    // oversized size with every upper bit set saturates
    write_total(32'hFFFF_FFFF);
    send_request(mk_req(200, 300), 0);
    send_request(mk_req(600, 1024), 0);
    write_total(32'd600);
    send_request(mk_req(550, 100), 0);
    send_request(mk_req(550, 50), 7);
    write_total(32'd1024);

    // random phases over several device sizes
    phase_total[0] = 32'd1024;
    phase_total[1] = 32'($urandom_range(1, 1023));
    phase_total[2] = 32'hFFFF_F800;
    phase_total[3] = $urandom();
    phase_total[4] = 32'd1;
    phase_total[5] = 32'd1023;
    phase_total[6] = 32'd2047;
    no_gaps = 1'b0;
    for (int p = 0; p < 7; p++) begin
      write_total(phase_total[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        send_request(random_request(), gap);
        if (n == PHASE_ITEMS / 2) wait_drain();
      end
    end

    wait_drain();
    repeat (SETTLE) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("contiguous_extent_allocator_top regression: pass");
    end else begin
      $display("contiguous_extent_allocator_top regression: fail");
    end
    $finish;
  end

endmodule
